// ----- sv/sha256_pkg.sv -----
package sha256_pkg;

  typedef enum logic [1:0] {
    REQ_ABSORB  = 2'd0,
    REQ_DIGEST  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- sv/sha256_if.sv -----
interface sha256_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface sha256_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/sha256_round.sv -----
// One compression round: working variables and message schedule word.
module sha256_round import sha256_pkg::*; (
  input  logic [255:0] v_i,
  input  logic [31:0]  w_i,
  input  logic [5:0]   t_i,
  output logic [255:0] v_o
);
  logic [31:0] a, b, c, d, e, f, g, h, s0, s1, ch, mj, t1, t2;
  always_comb begin
    {a, b, c, d, e, f, g, h} = v_i;
    s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch = (e & f) ^ (~e & g);
    t1 = h + s1 + ch + round_k(t_i) + w_i;
    s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mj = (a & b) ^ (a & c) ^ (b & c);
    t2 = s0 + mj;
    v_o = {t1 + t2, a, b, c, d + t1, e, f, g};
  end
endmodule

// ----- sv/sha256_sched.sv -----
// Rolling 16-word message schedule.
module sha256_sched import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        feed_sel_i,
  input  logic [31:0] feed_i,
  input  logic        shift_i,
  output logic [31:0] w_o
);
  logic [31:0] w_q [16];
  logic [31:0] g0, g1, wn;
  always_comb begin
    g1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    g0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    wn = g1 + w_q[9] + g0 + w_q[0];
  end
  // words 0..15 come from the block, later ones from the recurrence
  assign w_o = feed_sel_i ? feed_i : wn;
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_o;
    end
  end
endmodule

// ----- sv/sha256_stream_hasher_core.sv -----
// Absorb: one byte per accepted request; every 64th byte starts a compression (64 rounds,
// one a cycle, plus a load step and a hash update) in the single shared round unit.
// Digest: compresses one or two padded blocks, then sends eight words, one per cycle
// when the sink is ready. Restart reloads the initial hash and clears the counters.
// Reset loads the initial hash values and clears the counters; buffer contents
// are undefined until written.
module sha256_stream_hasher_core import sha256_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_req_if.sink   req_i,
  sha256_dig_if.source dig_o
);
  localparam logic [2:0] S_IDLE = 3'd0, S_LOAD = 3'd1, S_ROUND = 3'd2,
                         S_ADD = 3'd3, S_OUT = 3'd4;

  // byte buffer memory, four bytes per word, big-endian within a word
  logic [31:0] buf_mem [16];
  logic [3:0]  rd_addr;
  logic [31:0] rd_q, feed;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [255:0] hash_q, hash_d, hv_q, hv_d, v_q, v_d, v_next;
  logic [2:0]  st_q, st_d;
  logic [5:0]  t_q, t_d;
  logic        dig_q, dig_d, two_q, two_d, second_q, second_d;
  logic [2:0]  oi_q, oi_d;
  logic [31:0] w;
  logic        acc;

  assign acc = req_i.valid && req_i.ready;
  assign req_i.ready = (st_q == S_IDLE);

  // word t+1 is fetched during round t
  assign rd_addr = (st_q == S_ROUND) ? t_q[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk_i) begin
    if (acc && req_i.req_type == REQ_ABSORB)
      buf_mem[fill_q[5:2]][31 - 8*fill_q[1:0] -: 8] <= req_i.data_byte;
    rd_q <= buf_mem[rd_addr];
  end

  always_comb begin
    logic [63:0] total;
    total = bits_q + {55'd0, fill_q, 3'd0};
    for (int k = 0; k < 4; k++) begin
      logic [5:0] bi;
      logic [7:0] bv;
      bi = {t_q[3:0], 2'(k)};
      if (!dig_q) bv = rd_q[31 - 8*k -: 8];
      else if (second_q || !two_q) begin
        if (bi >= 6'd56) bv = total[63 - 8*bi[2:0] -: 8];
        else if (second_q) bv = 8'd0;
        else if (bi < fill_q) bv = rd_q[31 - 8*k -: 8];
        else if (bi == fill_q) bv = 8'h80;
        else bv = 8'd0;
      end else begin
        if (bi < fill_q) bv = rd_q[31 - 8*k -: 8];
        else if (bi == fill_q) bv = 8'h80;
        else bv = 8'd0;
      end
      feed[31 - 8*k -: 8] = bv;
    end
  end

  sha256_sched u_sched (
    .clk_i, .feed_sel_i(t_q[5:4] == 2'd0), .feed_i(feed), .shift_i(st_q == S_ROUND),
    .w_o(w)
  );

  sha256_round u_round (.v_i(v_q), .w_i(w), .t_i(t_q), .v_o(v_next));

  always_comb begin
    st_d = st_q; t_d = t_q; fill_d = fill_q; bits_d = bits_q;
    hash_d = hash_q; hv_d = hv_q; v_d = v_q;
    dig_d = dig_q; two_d = two_q; second_d = second_q; oi_d = oi_q;
    unique case (st_q)
      S_IDLE: if (acc) begin
        unique case (req_i.req_type)
          REQ_ABSORB: begin
            fill_d = fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              dig_d = 1'b0; st_d = S_LOAD; hv_d = hash_q;
            end
          end
          REQ_DIGEST: begin
            dig_d = 1'b1; second_d = 1'b0; two_d = (fill_q >= 6'd56);
            hv_d = hash_q; st_d = S_LOAD;
          end
          REQ_RESTART: begin
            hash_d = H_INIT; fill_d = '0; bits_d = '0;
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        v_d = hv_q; t_d = '0; st_d = S_ROUND;
      end
      S_ROUND: begin
        v_d = v_next; t_d = t_q + 6'd1;
        if (t_q == 6'd63) st_d = S_ADD;
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) hv_d[32*i +: 32] = hv_q[32*i +: 32] + v_q[32*i +: 32];
        if (!dig_q) begin
          hash_d = hv_d; bits_d = bits_q + 64'd512; st_d = S_IDLE;
        end else if (two_q && !second_q) begin
          second_d = 1'b1; st_d = S_LOAD;
        end else begin
          oi_d = '0; st_d = S_OUT;
        end
      end
      S_OUT: if (dig_o.ready) begin
        oi_d = oi_q + 3'd1;
        if (oi_q == 3'd7) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign dig_o.valid = (st_q == S_OUT);
  assign dig_o.digest_word = hv_q[255 - 32*oi_q -: 32];
  assign dig_o.word_index = oi_q;
  assign dig_o.last_word = (oi_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; fill_q <= '0; bits_q <= '0; hash_q <= H_INIT;
      t_q <= '0; dig_q <= 1'b0; two_q <= 1'b0; second_q <= 1'b0; oi_q <= '0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; bits_q <= bits_d; hash_q <= hash_d;
      t_q <= t_d; dig_q <= dig_d; two_q <= two_d; second_q <= second_d; oi_q <= oi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hv_q <= hv_d; v_q <= v_d;
  end
endmodule

// ----- tb/tb_sha256_stream_hasher_core.sv -----
module tb_sha256_stream_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_pkg::*;

  typedef struct {
    req_e     kind;
    bit [7:0] data;
    bit       wait_idle;
  } req_item_t;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  idx;
    bit        last;
  } digest_word_t;

  localparam bit [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic clk_i;
  logic rst_ni;

  sha256_req_if req_if ();
  sha256_dig_if dig_if ();

  sha256_stream_hasher_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .dig_o  (dig_if.source)
  );

  req_item_t    pending_req[$];
  digest_word_t digest_q[$];
  int           n_errors;
  int           n_accepted;
  int           n_total;
  int           src_idle_pct;
  int           snk_idle_pct;

  bit [31:0] run_hash[8];
  bit [7:0]  msg_block[64];
  int        msg_fill;
  bit [63:0] msg_bits;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic bit [31:0] ror(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block(inout bit [31:0] hv[8], input bit [7:0] blk[64]);
    bit [31:0] w[16];
    bit [31:0] v[8];
    bit [31:0] wt, t1, t2, x2, x15;
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end else begin
        x2  = w[(t - 2) & 15];
        x15 = w[(t - 15) & 15];
        wt = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[(t - 7) & 15]
           + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[t & 15];
      end
      w[t & 15] = wt;
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) run_hash[i] = H_INIT[255 - 32*i -: 32];
    msg_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void predict_hash(req_e kind, bit [7:0] data);
    bit [31:0] hv[8];
    bit [7:0]  pad[64];
    bit [63:0] total;
    digest_word_t d;
    case (kind)
      REQ_ABSORB: begin
        msg_block[msg_fill] = data;
        msg_fill++;
        if (msg_fill == 64) begin
          compress_block(run_hash, msg_block);
          msg_bits += 64'd512;
          msg_fill = 0;
        end
      end
      REQ_RESTART: restart_hash();
      REQ_DIGEST: begin
        hv = run_hash;
        pad = msg_block;
        pad[msg_fill] = 8'h80;
        for (int i = msg_fill + 1; i < 64; i++) pad[i] = 8'h00;
        if (msg_fill >= 56) begin
          compress_block(hv, pad);
          for (int i = 0; i < 56; i++) pad[i] = 8'h00;
        end
        total = msg_bits + 64'(msg_fill) * 64'd8;
        for (int i = 0; i < 8; i++) pad[56 + i] = total[63 - 8*i -: 8];
        compress_block(hv, pad);
        for (int i = 0; i < 8; i++) begin
          d.word = hv[i];
          d.idx  = 3'(i);
          d.last = (i == 7);
          digest_q.push_back(d);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
    n_errors++;
  endtask

  function automatic void push_req(req_e kind, bit [7:0] data = 8'h00, bit hold = 1'b0);
    req_item_t r;
    r.kind = kind;
    r.data = data;
    r.wait_idle = hold;
    pending_req.push_back(r);
  endfunction

  always_comb begin
    if (n_accepted < n_total / 3) begin
      src_idle_pct = 15;
      snk_idle_pct = 45;
    end else if (n_accepted < 2 * n_total / 3) begin
      src_idle_pct = 45;
      snk_idle_pct = 15;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.req_type  <= REQ_NONE;
      req_if.data_byte <= 8'h00;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_hash(req_e'(req_if.req_type), req_if.data_byte);
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_req.size() > 0 && $urandom_range(0, 99) >= src_idle_pct &&
            (!pending_req[0].wait_idle || digest_q.size() == 0)) begin
          req_if.valid     <= 1'b1;
          req_if.req_type  <= pending_req[0].kind;
          req_if.data_byte <= pending_req[0].data;
          void'(pending_req.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // digest monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_if.ready <= 1'b0;
    end else begin
      if (dig_if.valid && dig_if.ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected word", dig_if.digest_word, 32'h0);
        end else begin
          if (dig_if.digest_word !== digest_q[0].word)
            report_mismatch("digest_word", dig_if.digest_word, digest_q[0].word);
          if (dig_if.word_index !== digest_q[0].idx)
            report_mismatch("word_index", 32'(dig_if.word_index), 32'(digest_q[0].idx));
          if (dig_if.last_word !== digest_q[0].last)
            report_mismatch("last_word", 32'(dig_if.last_word), 32'(digest_q[0].last));
          void'(digest_q.pop_front());
        end
      end
      dig_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  initial begin
    int len;
    int sel;
    n_errors = 0;
    n_accepted = 0;
    rst_ni = 1'b0;
    restart_hash();

    // directed: empty message, byte extremes, unused request, restart mid-message
    push_req(REQ_DIGEST);
    push_req(REQ_ABSORB, 8'hff);
    push_req(REQ_ABSORB, 8'h00);
    push_req(REQ_NONE, 8'h5a);
    push_req(REQ_DIGEST);
    push_req(REQ_ABSORB, 8'h80);
    push_req(REQ_DIGEST);
    push_req(REQ_RESTART);
    push_req(REQ_DIGEST);
    push_req(REQ_ABSORB, 8'h01);
    push_req(REQ_RESTART, 8'hff);
    push_req(REQ_ABSORB, 8'h7f);
    push_req(REQ_DIGEST, 8'hff, 1'b1);

    // random messages, lengths weighted toward padding boundaries
    while (pending_req.size() < 165) begin
      push_req(REQ_RESTART, 8'($urandom_range(0, 255)));
      sel = $urandom_range(0, 9);
      if (sel < 4) len = $urandom_range(0, 20);
      else if (sel < 8) len = 54 + $urandom_range(0, 11);
      else len = $urandom_range(100, 130);
      for (int i = 0; i < len && pending_req.size() < 168; i++) begin
        if ($urandom_range(0, 29) == 0) push_req(REQ_NONE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 39) == 0) push_req(REQ_DIGEST);
        push_req(REQ_ABSORB, 8'($urandom_range(0, 255)));
      end
      push_req(REQ_DIGEST, 8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
    end
    n_total = pending_req.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_req.size() == 0 && n_accepted == n_total);
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
